// ----- src/psched_pkg.sv -----
// Package for the periodic service scheduler: field widths, opcode and
// result codes, and the command/status structs shared by controller and datapath.
// No dependencies.
`default_nettype none

package psched_pkg;

    localparam int NUM_SLOTS_DEF = 16;
    localparam int MAX_RESULTS   = 16;
    localparam int MS_PER_SEC    = 1000;

    localparam int OP_W     = 3;
    localparam int NOW_W    = 32;
    localparam int RATE_W   = 16;
    localparam int SLOT_W   = 4;
    localparam int KIND_W   = 2;
    localparam int PERIOD_W = 10;
    localparam int QUOT_W   = 10;

    localparam logic [OP_W-1:0] OP_CLEAR    = 3'd0;
    localparam logic [OP_W-1:0] OP_NEW      = 3'd1;
    localparam logic [OP_W-1:0] OP_DELETE   = 3'd2;
    localparam logic [OP_W-1:0] OP_PAUSE    = 3'd3;
    localparam logic [OP_W-1:0] OP_RESUME   = 3'd4;
    localparam logic [OP_W-1:0] OP_DISPATCH = 3'd5;

    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FAIL  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIRE  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE  = 2'd3;

    typedef struct packed {
        logic latch;
        logic clear_all;
        logic del;
        logic pause;
        logic resume;
        logic new_init;
        logic new_step;
        logic new_commit;
        logic scan_init;
        logic scan_step;
        logic scan_finish;
    } t_dp_cmd;

    typedef struct packed {
        logic new_done;
        logic fire;
        logic pend_valid;
        logic out_can_load;
        logic scan_last;
    } t_dp_status;

endpackage

`default_nettype wire

// ----- src/psched_in_if.sv -----
// Input channel interface of the periodic service scheduler.
// Depends on psched_pkg.
`default_nettype none

interface psched_in_if;
    logic                              valid;
    logic                              ready;
    logic [psched_pkg::OP_W-1:0]       opcode;
    logic [psched_pkg::NOW_W-1:0]      now_ms;
    logic [psched_pkg::RATE_W-1:0]     rate;
    logic                              start_paused;
    logic [psched_pkg::SLOT_W-1:0]     slot;

    modport source (output valid, output opcode, output now_ms, output rate,
                    output start_paused, output slot, input ready);
    modport sink   (input valid, input opcode, input now_ms, input rate,
                    input start_paused, input slot, output ready);
endinterface

`default_nettype wire

// ----- src/psched_out_if.sv -----
// Result channel interface of the periodic service scheduler.
// Depends on psched_pkg.
`default_nettype none

interface psched_out_if;
    logic                              valid;
    logic                              ready;
    logic [psched_pkg::KIND_W-1:0]     kind;
    logic [psched_pkg::SLOT_W-1:0]     slot_id;
    logic                              last;

    modport source (output valid, output kind, output slot_id, output last, input ready);
    modport sink   (input valid, input kind, input slot_id, input last, output ready);
endinterface

`default_nettype wire

// ----- src/psched_ctrl.sv -----
// Controller state machine of the periodic service scheduler.
// Depends on psched_pkg; drives command signals into psched_datapath.
`default_nettype none

module psched_ctrl (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    input  wire logic [psched_pkg::OP_W-1:0]    i_opcode,
    output logic                                o_in_ready,
    output psched_pkg::t_dp_cmd                 o_cmd,
    input  wire psched_pkg::t_dp_status         i_status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_NEW,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    unique case (i_opcode)
                        psched_pkg::OP_CLEAR:  o_cmd.clear_all = 1'b1;
                        psched_pkg::OP_NEW: begin
                            o_cmd.new_init = 1'b1;
                            n_state        = S_NEW;
                        end
                        psched_pkg::OP_DELETE: o_cmd.del = 1'b1;
                        psched_pkg::OP_PAUSE:  o_cmd.pause = 1'b1;
                        psched_pkg::OP_RESUME: o_cmd.resume = 1'b1;
                        psched_pkg::OP_DISPATCH: begin
                            o_cmd.scan_init = 1'b1;
                            n_state         = S_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            S_NEW: begin
                if (!i_status.new_done) begin
                    o_cmd.new_step = 1'b1;
                end else if (i_status.out_can_load) begin
                    o_cmd.new_commit = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_SCAN: begin
                if (!(i_status.fire && i_status.pend_valid && !i_status.out_can_load)) begin
                    o_cmd.scan_step = 1'b1;
                    if (i_status.scan_last) begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_FINISH: begin
                if (i_status.out_can_load) begin
                    o_cmd.scan_finish = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ----- src/psched_datapath.sv -----
// Datapath of the periodic service scheduler: slot flags, period and deadline
// memories, the 1000/rate divider, the slot scanners and the result register.
// Depends on psched_pkg; commanded by psched_ctrl.
`default_nettype none

module psched_datapath #(
    parameter int NUM_SLOTS = psched_pkg::NUM_SLOTS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire psched_pkg::t_dp_cmd              i_cmd,
    output psched_pkg::t_dp_status                o_status,
    input  wire logic [psched_pkg::NOW_W-1:0]     i_now_ms,
    input  wire logic [psched_pkg::RATE_W-1:0]    i_rate,
    input  wire logic                             i_start_paused,
    input  wire logic [psched_pkg::SLOT_W-1:0]    i_slot,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic [psched_pkg::KIND_W-1:0]         o_out_kind,
    output logic [psched_pkg::SLOT_W-1:0]         o_out_slot_id,
    output logic                                  o_out_last
);

    localparam int NOW_W    = psched_pkg::NOW_W;
    localparam int RATE_W   = psched_pkg::RATE_W;
    localparam int SLOT_W   = psched_pkg::SLOT_W;
    localparam int KIND_W   = psched_pkg::KIND_W;
    localparam int PERIOD_W = psched_pkg::PERIOD_W;
    localparam int QUOT_W   = psched_pkg::QUOT_W;
    localparam int IDX_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W    = $clog2(psched_pkg::MAX_RESULTS + 1);
    localparam int DCNT_W   = $clog2(QUOT_W + 1);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(NUM_SLOTS - 1);
    localparam logic [CNT_W-1:0]  MAX_FIRE  = CNT_W'(psched_pkg::MAX_RESULTS);
    localparam logic [DCNT_W-1:0] LAST_STEP = DCNT_W'(QUOT_W - 1);

    logic [NOW_W-1:0]    r_now;
    logic [RATE_W-1:0]   r_rate;
    logic                r_start_paused;

    logic [NUM_SLOTS-1:0] r_active;
    logic [NUM_SLOTS-1:0] r_paused;
    logic [PERIOD_W-1:0]  r_period_mem [NUM_SLOTS];
    logic [NOW_W-1:0]     r_deadline_mem [NUM_SLOTS];
    logic [PERIOD_W-1:0]  r_per_q;
    logic [NOW_W-1:0]     r_dl_q;

    logic [IDX_W-1:0]    r_idx;
    logic [CNT_W-1:0]    r_nfire;
    logic                r_pend_valid;
    logic [IDX_W-1:0]    r_pend_idx;

    logic [IDX_W-1:0]    r_fidx;
    logic                r_fdone;
    logic                r_found;

    logic [QUOT_W-1:0]   r_dvd;
    logic [RATE_W-1:0]   r_rem;
    logic [QUOT_W-1:0]   r_quot;
    logic [DCNT_W-1:0]   r_dcnt;
    logic                r_ddone;

    logic                r_out_valid;
    logic [KIND_W-1:0]   r_out_kind;
    logic [SLOT_W-1:0]   r_out_slot;
    logic                r_out_last;

    logic [IDX_W-1:0]    slot_idx;
    logic                slot_ok;
    logic [NOW_W-1:0]    dl_diff;
    logic                fire;
    logic [PERIOD_W-1:0] per_eff;
    logic [NOW_W-1:0]    next_dl;
    logic [NOW_W-1:0]    new_dl;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [NOW_W-1:0]    wr_dl;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic [RATE_W:0]     trial;
    logic [RATE_W:0]     trial_sub;
    logic                trial_ge;
    logic                out_can_load;
    logic                out_load;
    logic [KIND_W-1:0]   out_kind;
    logic [SLOT_W-1:0]   out_slot;
    logic                out_last;

    assign slot_idx = IDX_W'(i_slot);
    assign slot_ok  = (32'(i_slot) < NUM_SLOTS);

    assign dl_diff = r_now - r_dl_q;
    assign fire    = r_active[r_idx] & ~r_paused[r_idx] & ~dl_diff[NOW_W-1]
                     & (r_nfire < MAX_FIRE);
    assign per_eff = (r_per_q == '0) ? PERIOD_W'(1) : r_per_q;
    assign next_dl = r_now + NOW_W'(per_eff);
    assign new_dl  = r_now + NOW_W'(r_quot);

    assign wr_en   = (i_cmd.new_commit & r_found) | (i_cmd.scan_step & fire);
    assign wr_addr = i_cmd.new_commit ? r_fidx : r_idx;
    assign wr_dl   = i_cmd.new_commit ? new_dl : next_dl;
    assign rd_en   = i_cmd.scan_init | (i_cmd.scan_step & (r_idx != LAST_IDX));
    assign rd_addr = i_cmd.scan_init ? '0 : r_idx + 1'b1;

    assign trial     = {r_rem, r_dvd[QUOT_W-1]};
    assign trial_sub = trial - {1'b0, r_rate};
    assign trial_ge  = (trial >= {1'b0, r_rate});

    assign out_can_load = ~r_out_valid | i_out_ready;

    always_comb begin
        out_load = 1'b0;
        out_kind = psched_pkg::KIND_NONE;
        out_slot = '0;
        out_last = 1'b1;
        priority if (i_cmd.new_commit) begin
            out_load = 1'b1;
            out_kind = r_found ? psched_pkg::KIND_ALLOC : psched_pkg::KIND_FAIL;
            out_slot = r_found ? SLOT_W'(r_fidx) : '0;
        end else if (i_cmd.scan_step && fire && r_pend_valid) begin
            out_load = 1'b1;
            out_kind = psched_pkg::KIND_FIRE;
            out_slot = SLOT_W'(r_pend_idx);
            out_last = 1'b0;
        end else if (i_cmd.scan_finish) begin
            out_load = 1'b1;
            out_kind = r_pend_valid ? psched_pkg::KIND_FIRE : psched_pkg::KIND_NONE;
            out_slot = r_pend_valid ? SLOT_W'(r_pend_idx) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_now          <= i_now_ms;
            r_rate         <= (i_rate == '0) ? RATE_W'(1) : i_rate;
            r_start_paused <= i_start_paused;
        end
        if (i_cmd.new_commit && r_found) begin
            r_period_mem[r_fidx] <= PERIOD_W'(r_quot);
        end
        if (wr_en) begin
            r_deadline_mem[wr_addr] <= wr_dl;
        end
        if (rd_en) begin
            r_per_q <= r_period_mem[rd_addr];
            r_dl_q  <= r_deadline_mem[rd_addr];
        end
        if (i_cmd.scan_step && fire) begin
            r_pend_idx <= r_idx;
        end
        if (i_cmd.new_init) begin
            r_dvd <= QUOT_W'(psched_pkg::MS_PER_SEC);
            r_rem <= '0;
        end else if (i_cmd.new_step && !r_ddone) begin
            r_dvd  <= {r_dvd[QUOT_W-2:0], 1'b0};
            r_rem  <= trial_ge ? trial_sub[RATE_W-1:0] : trial[RATE_W-1:0];
            r_quot <= {r_quot[QUOT_W-2:0], trial_ge};
        end
        if (out_load) begin
            r_out_kind <= out_kind;
            r_out_slot <= out_slot;
            r_out_last <= out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= '0;
            r_paused     <= '0;
            r_idx        <= '0;
            r_nfire      <= '0;
            r_pend_valid <= 1'b0;
            r_fidx       <= '0;
            r_fdone      <= 1'b0;
            r_found      <= 1'b0;
            r_dcnt       <= '0;
            r_ddone      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.clear_all) begin
                r_active <= '0;
            end
            if (i_cmd.del && slot_ok) begin
                r_active[slot_idx] <= 1'b0;
            end
            if (i_cmd.pause && slot_ok) begin
                r_paused[slot_idx] <= 1'b1;
            end
            if (i_cmd.resume && slot_ok) begin
                r_paused[slot_idx] <= 1'b0;
            end
            if (i_cmd.new_commit && r_found) begin
                r_active[r_fidx] <= 1'b1;
                r_paused[r_fidx] <= r_start_paused;
            end

            if (i_cmd.new_init) begin
                r_fidx  <= '0;
                r_fdone <= 1'b0;
                r_found <= 1'b0;
                r_dcnt  <= '0;
                r_ddone <= 1'b0;
            end else if (i_cmd.new_step) begin
                if (!r_fdone) begin
                    if (!r_active[r_fidx]) begin
                        r_found <= 1'b1;
                        r_fdone <= 1'b1;
                    end else if (r_fidx == LAST_IDX) begin
                        r_fdone <= 1'b1;
                    end else begin
                        r_fidx <= r_fidx + 1'b1;
                    end
                end
                if (!r_ddone) begin
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == LAST_STEP) begin
                        r_ddone <= 1'b1;
                    end
                end
            end

            if (i_cmd.scan_init) begin
                r_idx        <= '0;
                r_nfire      <= '0;
                r_pend_valid <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_idx <= r_idx + 1'b1;
                if (fire) begin
                    r_nfire      <= r_nfire + 1'b1;
                    r_pend_valid <= 1'b1;
                end
            end else if (i_cmd.scan_finish) begin
                r_pend_valid <= 1'b0;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_status.new_done     = r_ddone & r_fdone;
        o_status.fire         = fire;
        o_status.pend_valid   = r_pend_valid;
        o_status.out_can_load = out_can_load;
        o_status.scan_last    = (r_idx == LAST_IDX);
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_kind    = r_out_kind;
    assign o_out_slot_id = r_out_slot;
    assign o_out_last    = r_out_last;

endmodule

`default_nettype wire

// ----- src/periodic_service_scheduler_core.sv -----
// Dispatch reads the deadline memory through its registered port one slot per cycle, stalling
// while a fire result waits on the result register; a finish state closes the scan.
// New service waits for the ten-step 1000/rate divider and the free-slot search beside it,
// then for the result register. Clear, delete, pause and resume take effect when taken.
// Synchronous active-low reset empties the table; period and deadline memories keep contents.
`default_nettype none

module periodic_service_scheduler_core #(
    parameter int NUM_SLOTS = psched_pkg::NUM_SLOTS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    psched_in_if.sink        i_in,
    psched_out_if.source     o_out
);

    psched_pkg::t_dp_cmd    cmd;
    psched_pkg::t_dp_status status;

    psched_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_opcode   (i_in.opcode),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    psched_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_now_ms       (i_in.now_ms),
        .i_rate         (i_in.rate),
        .i_start_paused (i_in.start_paused),
        .i_slot         (i_in.slot),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_out_kind     (o_out.kind),
        .o_out_slot_id  (o_out.slot_id),
        .o_out_last     (o_out.last)
    );

endmodule

`default_nettype wire
